// ===== rtl/rac_pkg.sv =====
`timescale 1ns / 1ps
package rac_pkg;

	// Controller states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_SUM  = 6'b000100,
		ST_GCD  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic gcd_step;
		logic div_init;
		logic div_step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad;
		logic zero_sum;
		logic gcd_done;
		logic div_done;
	} stat_t;

endpackage

// ===== rtl/rational_add_compare.sv =====
`timescale 1ns / 1ps
// Adds two signed fractions, reduces the sum by Euclid's GCD and compares them.
// Assert start while busy is low to transfer one item; the result appears for
// exactly one cycle with done high and cannot be stalled, so capture it then.
// Each Euclid step and each of the two final divides runs the bit-serial
// shift-subtract divider, so the time an item takes depends on the data
// through the number of Euclid steps.
module rational_add_compare
	import rac_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	output logic                    done,
	input  logic signed [WIDTH-1:0] a_num,
	input  logic signed [WIDTH-1:0] a_den,
	input  logic signed [WIDTH-1:0] b_num,
	input  logic signed [WIDTH-1:0] b_den,
	output logic signed [WIDTH-1:0] sum_num,
	output logic        [WIDTH-2:0] sum_den,
	output logic                    a_less_b,
	output logic                    a_equal_b,
	output logic                    bad_denominator,
	output logic                    overflow
);

	cmd_t  cmd;
	stat_t stat;

	// Controller.
	rac_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.done(done), .cmd(cmd), .stat(stat)
	);

	// Datapath.
	rac_dp #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.cmd(cmd), .stat(stat), .sum_num(sum_num), .sum_den(sum_den),
		.a_less_b(a_less_b), .a_equal_b(a_equal_b),
		.bad_denominator(bad_denominator), .overflow(overflow)
	);

endmodule

// ===== rtl/rac_ctrl.sv =====
`timescale 1ns / 1ps
module rac_ctrl
	import rac_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output logic  done,
	output cmd_t  cmd,
	input  stat_t stat
);

	state_t state_q, state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (stat.bad) begin
					state_d = ST_DONE;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_GCD;
			end
			ST_GCD: begin
				if (stat.zero_sum) begin
					state_d = ST_DONE;
				end else if (stat.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// ===== rtl/rac_dp.sv =====
`timescale 1ns / 1ps
module rac_dp
	import rac_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic                    clk,
	input  logic signed [WIDTH-1:0] a_num,
	input  logic signed [WIDTH-1:0] a_den,
	input  logic signed [WIDTH-1:0] b_num,
	input  logic signed [WIDTH-1:0] b_den,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	output logic signed [WIDTH-1:0] sum_num,
	output logic        [WIDTH-2:0] sum_den,
	output logic                    a_less_b,
	output logic                    a_equal_b,
	output logic                    bad_denominator,
	output logic                    overflow
);

	localparam int W1 = WIDTH + 1;
	localparam int PW = 2 * WIDTH + 2;
	localparam int CW = $clog2(PW + 1);

	logic signed [W1-1:0] an_q, ad_q, bn_q, bd_q;
	logic                 bad_q;
	logic signed [PW-1:0] p1_q, p2_q;
	logic        [PW-1:0] den_q, smag_q, x_q, y_q, rem_q, quo_q, dv_q;
	logic                 sneg_q, lt_q, eq_q;
	logic        [1:0]    div_phase_q;
	logic        [CW-1:0] cnt_q;
	logic        [PW-1:0] mod_x_q;
	logic                 mod_busy_q;

	// Operands widened by one bit so that the sign-normalizing negation is exact.
	logic signed [W1-1:0] an_e, ad_e, bn_e, bd_e;
	assign an_e = W1'(a_num);
	assign ad_e = W1'(a_den);
	assign bn_e = W1'(b_num);
	assign bd_e = W1'(b_den);

	// Shift-subtract step shared by the GCD remainder and the final divides.
	logic [PW:0]   trial;
	logic [PW-1:0] rem_sh;
	assign rem_sh = {rem_q[PW-2:0], quo_q[PW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dv_q};

	logic [PW-1:0] smag_d;
	logic          sneg_d;
	always_comb begin
		logic [PW-1:0] m1, m2;
		m1 = p1_q[PW-1] ? PW'(-p1_q) : PW'(p1_q);
		m2 = p2_q[PW-1] ? PW'(-p2_q) : PW'(p2_q);
		if (p1_q[PW-1] == p2_q[PW-1]) begin
			smag_d = m1 + m2;
			sneg_d = p1_q[PW-1];
		end else if (m1 >= m2) begin
			smag_d = m1 - m2;
			sneg_d = p1_q[PW-1];
		end else begin
			smag_d = m2 - m1;
			sneg_d = p2_q[PW-1];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bad_q <= (a_den == '0) || (b_den == '0);
			an_q  <= a_den[WIDTH-1] ? -an_e : an_e;
			ad_q  <= a_den[WIDTH-1] ? -ad_e : ad_e;
			bn_q  <= b_den[WIDTH-1] ? -bn_e : bn_e;
			bd_q  <= b_den[WIDTH-1] ? -bd_e : bd_e;
			smag_q <= '0;
		end
		if (cmd.mul) begin
			p1_q  <= PW'(an_q) * PW'(bd_q);
			p2_q  <= PW'(bn_q) * PW'(ad_q);
			den_q <= PW'(ad_q) * PW'(bd_q);
		end
		if (cmd.sum) begin
			lt_q   <= p1_q < p2_q;
			eq_q   <= p1_q == p2_q;
			smag_q <= smag_d;
			sneg_q <= sneg_d;
			x_q    <= smag_d;
			y_q    <= den_q;
			mod_busy_q <= 1'b0;
		end
		// One GCD step: start a remainder x % y, advance it by one bit, or finish it and move on to (y, x % y).
		if (cmd.gcd_step) begin
			if (!mod_busy_q) begin
				mod_busy_q <= 1'b1;
				rem_q <= '0;
				quo_q <= x_q;
				dv_q  <= y_q;
				cnt_q <= CW'(PW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (!trial[PW]) begin
					rem_q <= trial[PW-1:0];
					quo_q <= {quo_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[PW-2:0], 1'b0};
				end
			end else begin
				mod_busy_q <= 1'b0;
				x_q <= y_q;
				y_q <= rem_q;
			end
		end
		// Final divides of the sum and the denominator by the GCD.
		if (cmd.div_init) begin
			div_phase_q <= 2'd0;
			rem_q <= '0;
			quo_q <= smag_q;
			dv_q  <= x_q;
			cnt_q <= CW'(PW);
		end
		if (cmd.div_step) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (!trial[PW]) begin
					rem_q <= trial[PW-1:0];
					quo_q <= {quo_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[PW-2:0], 1'b0};
				end
			end else begin
				div_phase_q <= div_phase_q + 2'd1;
				if (div_phase_q == 2'd0) begin
					mod_x_q <= quo_q;
					rem_q <= '0;
					quo_q <= den_q;
					cnt_q <= CW'(PW);
				end
			end
		end
	end

	assign stat.bad      = bad_q;
	assign stat.zero_sum = (smag_q == '0);
	assign stat.gcd_done = (y_q == '0) && !mod_busy_q;
	assign stat.div_done = (div_phase_q == 2'd2);

	// Result assembly from the registered quotients.
	logic ovf;
	always_comb begin
		logic [PW-1:0] lim_pos;
		lim_pos = PW'({(WIDTH-1){1'b1}});
		ovf = (sneg_q ? (mod_x_q > lim_pos + 1'b1) : (mod_x_q > lim_pos))
			|| (quo_q > lim_pos);
		sum_num = '0;
		sum_den = '0;
		a_less_b = 1'b0;
		a_equal_b = 1'b0;
		overflow = 1'b0;
		bad_denominator = bad_q;
		if (!bad_q) begin
			a_less_b  = lt_q;
			a_equal_b = eq_q;
			if (smag_q == '0) begin
				sum_den = (WIDTH-1)'(1);
			end else if (ovf) begin
				overflow = 1'b1;
			end else begin
				sum_num = sneg_q ? WIDTH'(-mod_x_q) : WIDTH'(mod_x_q);
				sum_den = quo_q[WIDTH-2:0];
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import rac_pkg::*;

	localparam int WIDTH = 32;
	localparam int N_RANDOM = 1780;

	typedef struct {
		logic signed [WIDTH-1:0] num;
		logic        [WIDTH-2:0] den;
		logic                    less;
		logic                    equal;
		logic                    bad;
		logic                    ovf;
	} sum_result_t;

	// Computes the expected sum and comparison flags for one operand set.
	function automatic sum_result_t fraction_sum(input logic signed [WIDTH-1:0] an_i,
			input logic signed [WIDTH-1:0] ad_i, input logic signed [WIDTH-1:0] bn_i,
			input logic signed [WIDTH-1:0] bd_i);
		sum_result_t r;
		longint an, ad, bn, bd, p1, p2, s;
		longint unsigned mag, den, x, y, t, lim;
		logic neg;
		r = '{num: '0, den: '0, less: 1'b0, equal: 1'b0, bad: 1'b0, ovf: 1'b0};
		an = an_i; ad = ad_i; bn = bn_i; bd = bd_i;
		if (ad == 0 || bd == 0) begin
			r.bad = 1'b1;
			return r;
		end
		if (ad < 0) begin
			ad = -ad; an = -an;
		end
		if (bd < 0) begin
			bd = -bd; bn = -bn;
		end
		p1 = an * bd;
		p2 = bn * ad;
		r.less = p1 < p2;
		r.equal = p1 == p2;
		// Two positive products of 2^62 wrap to -2^63; the bits still give the magnitude.
		s = p1 + p2;
		neg = (p1 > 0 && p2 > 0) ? 1'b0 : (s < 0);
		mag = neg ? -s : s;
		den = ad * bd;
		if (mag == 0) begin
			r.den = (WIDTH-1)'(1);
			return r;
		end
		x = mag; y = den;
		while (y != 0) begin
			t = x % y; x = y; y = t;
		end
		mag = mag / x;
		den = den / x;
		lim = (64'd1 << (WIDTH - 1)) - 1;
		if ((neg ? mag > lim + 1 : mag > lim) || den > lim) begin
			r.ovf = 1'b1;
			return r;
		end
		r.num = WIDTH'(neg ? -mag : mag);
		r.den = den[WIDTH-2:0];
		return r;
	endfunction

	// Holds the expected sums in order of transfer and compares results to them.
	class sum_scoreboard;
		sum_result_t pending[$];
		int errors;

		function void note_transfer(input logic signed [WIDTH-1:0] an,
				input logic signed [WIDTH-1:0] ad, input logic signed [WIDTH-1:0] bn,
				input logic signed [WIDTH-1:0] bd);
			pending.push_back(fraction_sum(an, ad, bn, bd));
		endfunction

		function void check_result(input sum_result_t got);
			sum_result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing pending: %0d/%0d", $realtime,
					got.num, got.den);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.num !== exp.num) begin
				$display("%0t: sum_num expected %0d actual %0d", $realtime, exp.num, got.num);
				errors++;
			end
			if (got.den !== exp.den) begin
				$display("%0t: sum_den expected %0d actual %0d", $realtime, exp.den, got.den);
				errors++;
			end
			if (got.less !== exp.less) begin
				$display("%0t: a_less_b expected %b actual %b", $realtime, exp.less, got.less);
				errors++;
			end
			if (got.equal !== exp.equal) begin
				$display("%0t: a_equal_b expected %b actual %b", $realtime, exp.equal,
					got.equal);
				errors++;
			end
			if (got.bad !== exp.bad) begin
				$display("%0t: bad_denominator expected %b actual %b", $realtime, exp.bad,
					got.bad);
				errors++;
			end
			if (got.ovf !== exp.ovf) begin
				$display("%0t: overflow expected %b actual %b", $realtime, exp.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [WIDTH-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic signed [WIDTH-1:0] sum_num;
	logic        [WIDTH-2:0] sum_den;
	logic a_less_b, a_equal_b, bad_denominator, overflow;

	sum_scoreboard sb = new();
	int n_bad, n_ovf, n_zero;

	rational_add_compare #(.WIDTH(WIDTH)) dut (.*);

	always #1 clk = ~clk;

	// Capture each result on the edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (bad_denominator) n_bad++;
			if (overflow) n_ovf++;
			if (!bad_denominator && !overflow && sum_num == 0) n_zero++;
			sb.check_result('{num: sum_num, den: sum_den, less: a_less_b, equal: a_equal_b,
				bad: bad_denominator, ovf: overflow});
		end
	end

	// Drives one operand set after a random gap if may_idle, held until the transfer.
	// Start stays high from one transfer to the next when there is no gap.
	task automatic send_fractions(input logic signed [WIDTH-1:0] an,
			input logic signed [WIDTH-1:0] ad, input logic signed [WIDTH-1:0] bn,
			input logic signed [WIDTH-1:0] bd, input bit may_idle);
		int gap;
		gap = may_idle ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
		do @(posedge clk); while (busy);
		sb.note_transfer(an, ad, bn, bd);
	endtask

	// Random value: mostly small, sometimes near the extremes, sometimes full range.
	function automatic logic signed [WIDTH-1:0] pick_value(input bit nonzero);
		logic signed [WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $signed($urandom_range(0, 40)) - 20;
			4, 5: v = $signed($urandom_range(0, 2000)) - 1000;
			6: v = 32'sh7fff_ffff - $signed($urandom_range(0, 3));
			7: v = 32'sh8000_0000 + $signed($urandom_range(0, 3));
			default: v = $urandom();
		endcase
		if (nonzero && v == 0) v = 1;
		return v;
	endfunction

	initial begin
		logic signed [WIDTH-1:0] ad, bd, k;
		bit idle_phase;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero denominators, extremes, zero and equal sums, overflow.
		send_fractions(1, 0, 1, 2, 0);
		send_fractions(1, 2, 3, 0, 0);
		send_fractions(0, 0, 0, 0, 0);
		send_fractions(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
		send_fractions(32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1, 0);
		send_fractions(32'sh8000_0000, 1, -1, 1, 0);
		send_fractions(32'sh8000_0000, 1, 0, 1, 0);
		send_fractions(32'sh7fff_ffff, 1, 1, 1, 0);
		send_fractions(1, 32'sh8000_0000, 0, 5, 0);
		send_fractions(1, 32'sh7fff_ffff, 1, 32'sh7fff_fffe, 0);
		send_fractions(1, 3, -1, 3, 0);
		send_fractions(2, 4, 1, 2, 0);
		send_fractions(-1, -2, 1, 2, 0);
		send_fractions(1, -2, 1, 2, 0);
		send_fractions(3, 4, 1, 1, 0);
		send_fractions(3, 4, -1, 1, 0);
		send_fractions(0, -7, 0, 3, 0);
		send_fractions(-1, 32'sh8000_0000, 32'sh8000_0000, -1, 0);
		send_fractions(32'shffff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh7fff_ffff, 0);

		// Random: stretches with and without gaps; some sums built to cancel or match.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 150 == 0) idle_phase = $urandom_range(0, 1);
			ad = pick_value($urandom_range(0, 30) != 0);
			bd = pick_value($urandom_range(0, 30) != 0);
			case ($urandom_range(0, 5))
				0: begin
					k = $signed($urandom_range(1, 50)) * ($urandom_range(0, 1) ? 1 : -1);
					send_fractions(k, ad, -k, ad, idle_phase);
				end
				1: begin
					k = pick_value(0);
					send_fractions(k, ad, k, ad, idle_phase);
				end
				default: send_fractions(pick_value(0), ad, pick_value(0), bd, idle_phase);
			endcase
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d items plus directed cases: %0d bad denominators,",
			N_RANDOM, n_bad);
		$display("%0d overflows and %0d zero sums.", n_ovf, n_zero);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Run limit: about 1800 items, with ample margin.
	initial begin
		#200_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
